[rtl/gl_pkg.sv]
// Shared command and status types for the gcd/lcm unit.
`default_nettype none

package gl_pkg;

  typedef struct packed {
    logic load;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic mul;
    logic store;
  } gl_cmd_t;

  typedef struct packed {
    logic zero;
    logic gcd_done;
  } gl_stat_t;

endpackage

`default_nettype wire

[rtl/gl_in_if.sv]
// Operand channel interface: valid/ready handshake with two operands.
`default_nettype none

interface gl_in_if #(
  parameter int W = 16
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] first_value;
  logic [W-1:0] second_value;

  modport source (output valid, output first_value, output second_value, input ready);
  modport sink (input valid, input first_value, input second_value, output ready);
endinterface

`default_nettype wire

[rtl/gl_out_if.sv]
// Result channel interface: valid/ready handshake with divisor, multiple and flag.
`default_nettype none

interface gl_out_if #(
  parameter int W = 16
) ();
  logic           valid;
  logic           ready;
  logic [W-1:0]   divisor;
  logic [2*W-1:0] multiple;
  logic           invalid;

  modport source (output valid, output divisor, output multiple, output invalid, input ready);
  modport sink (input valid, input divisor, input multiple, input invalid, output ready);
endinterface

`default_nettype wire

[rtl/gl_dp.sv]
// Datapath: binary gcd, restoring divider, multiplier and result register.
`default_nettype none

module gl_dp
  import gl_pkg::*;
#(
  parameter int W = 16
) (
  input  wire logic           clk,
  input  wire gl_cmd_t        cmd,
  output gl_stat_t            stat,
  input  wire logic [W-1:0]   first_value,
  input  wire logic [W-1:0]   second_value,
  output logic [W-1:0]        divisor,
  output logic [2*W-1:0]      multiple,
  output logic                invalid
);

  localparam int KW = $clog2(W);
  localparam int MW = 2 * W;

  logic [W-1:0]  a_r, b_r, x_r, y_r, g_r, rem_r, quo_r;
  logic [KW-1:0] k_r;
  logic          zero_r;
  logic [MW-1:0] p_r;
  logic [W-1:0]  div_r;
  logic [MW-1:0] mul_r;
  logic          inv_r;

  logic          x_gt;
  logic [W-1:0]  diff;
  logic [W:0]    rem_sh;
  logic          ge;
  logic [W:0]    rem_sub;

  assign x_gt    = x_r > y_r;
  assign diff    = x_gt ? (x_r - y_r) : (y_r - x_r);
  assign rem_sh  = {rem_r, quo_r[W-1]};
  assign ge      = rem_sh >= {1'b0, g_r};
  assign rem_sub = rem_sh - {1'b0, g_r};

  assign stat.zero     = zero_r;
  assign stat.gcd_done = (x_r == y_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r    <= first_value;
      b_r    <= second_value;
      x_r    <= first_value;
      y_r    <= second_value;
      k_r    <= '0;
      zero_r <= (first_value == '0) || (second_value == '0);
    end else if (cmd.gcd_step) begin
      if (!x_r[0] && !y_r[0]) begin
        x_r <= x_r >> 1;
        y_r <= y_r >> 1;
        k_r <= k_r + KW'(1);
      end else if (!x_r[0]) begin
        x_r <= x_r >> 1;
      end else if (!y_r[0]) begin
        y_r <= y_r >> 1;
      end else if (x_gt) begin
        x_r <= diff >> 1;
      end else begin
        y_r <= diff >> 1;
      end
    end
    if (cmd.div_init) begin
      g_r   <= x_r << k_r;
      rem_r <= '0;
      quo_r <= a_r;
    end else if (cmd.div_step) begin
      rem_r <= ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
      quo_r <= {quo_r[W-2:0], ge};
    end
    if (cmd.mul) begin
      p_r <= MW'(quo_r) * MW'(b_r);
    end
    if (cmd.store) begin
      div_r <= zero_r ? '0 : g_r;
      mul_r <= zero_r ? '0 : p_r;
      inv_r <= zero_r;
    end
  end

  assign divisor  = div_r;
  assign multiple = mul_r;
  assign invalid  = inv_r;

endmodule

`default_nettype wire

[rtl/gl_ctrl.sv]
// Controller: sequences load, gcd, divide, multiply and result hand-off.
`default_nettype none

module gl_ctrl
  import gl_pkg::*;
#(
  parameter int W = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output gl_cmd_t       cmd,
  input  wire gl_stat_t stat
);

  localparam int CW = $clog2(W);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GCD  = 3'd1;
  localparam logic [2:0] S_GINI = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          oval_r, oval_nxt;
  logic          slot_free;

  assign slot_free = !oval_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = oval_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    oval_nxt  = oval_r && !out_ready;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_GCD;
        end
      end
      S_GCD: begin
        if (stat.zero) begin
          state_nxt = S_FIN;
        end else if (stat.gcd_done) begin
          state_nxt = S_GINI;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_GINI: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CW'(1);
        if (cnt_r == CW'(W - 1)) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.store = 1'b1;
          oval_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      oval_r  <= oval_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/gcd_lcm_unit.sv]
// Top level: gcd and lcm of two unsigned operands, controller plus datapath.
//
//   channel  | modport | payload                          | accepted when
//   in_ch    | sink    | first_value, second_value        | valid & ready
//   out_ch   | source  | divisor, multiple, invalid       | valid & ready
//
// One item at a time: each item goes through load, the binary gcd steps, divider
// setup, OPERAND_WIDTH divider steps for first_value / divisor, multiply and
// store. A zero operand skips straight from the gcd check to the store.
// Reset is synchronous, active low; it clears the controller and out valid.
// The result register frees the input side while a result stalls on out_ch.
`default_nettype none

module gcd_lcm_unit
  import gl_pkg::*;
#(
  parameter int OPERAND_WIDTH = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  gl_in_if.sink     in_ch,
  gl_out_if.source  out_ch
);

  gl_cmd_t  cmd;
  gl_stat_t stat;

  gl_ctrl #(
    .W (OPERAND_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  gl_dp #(
    .W (OPERAND_WIDTH)
  ) u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .stat         (stat),
    .first_value  (in_ch.first_value),
    .second_value (in_ch.second_value),
    .divisor      (out_ch.divisor),
    .multiple     (out_ch.multiple),
    .invalid      (out_ch.invalid)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken again right after accept");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.invalid |-> out_ch.divisor == '0 && out_ch.multiple == '0)
    else $error("invalid result carries nonzero values");

  a_valid_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.invalid |-> out_ch.divisor != '0 && out_ch.multiple != '0)
    else $error("valid result with zero divisor or multiple");

endmodule

`default_nettype wire
